// ===== src/gpt_pkg.sv =====
// shared types, codes and constants of the guide port pulse timer
package gpt_pkg;

  // pin count limits and defaults
  localparam int PIN_COUNT_DEF = 8;
  localparam int PORT_W        = 8;
  localparam int ACT_W         = 3;
  localparam int DUR_W         = 16;

  // register reset values and counter limits
  localparam logic [DUR_W-1:0] DEADTIME_RST = 16'd100;
  localparam logic [DUR_W-1:0] SINCE_MAX    = 16'hFFFF;
  localparam logic [DUR_W-1:0] ELAPSED_MAX  = 16'hFFFF;

  // configuration register indexes
  localparam logic [1:0] REG_PIN_ACTION_MAP  = 2'd0;
  localparam logic [1:0] REG_INVERT_OUTPUT   = 2'd1;
  localparam logic [1:0] REG_DEADTIME_ENABLE = 2'd2;
  localparam logic [1:0] REG_DEADTIME_MS     = 2'd3;

  // item kinds
  localparam logic KIND_TICK    = 1'b0;
  localparam logic KIND_REQUEST = 1'b1;

  // axis direction codes
  typedef logic [1:0] dir_t;
  localparam dir_t DIR_NONE  = 2'd0;
  localparam dir_t DIR_PLUS  = 2'd1;
  localparam dir_t DIR_MINUS = 2'd2;

  // pin action codes
  typedef logic [ACT_W-1:0] act_t;
  localparam act_t ACT_NONE      = 3'd0;
  localparam act_t ACT_RA_PLUS   = 3'd1;
  localparam act_t ACT_RA_MINUS  = 3'd2;
  localparam act_t ACT_DEC_PLUS  = 3'd3;
  localparam act_t ACT_DEC_MINUS = 3'd4;

  // configuration set
  typedef struct packed {
    logic [3*PORT_W-1:0] pin_action_map;
    logic                invert_output;
    logic                deadtime_enable;
    logic [DUR_W-1:0]    deadtime_ms;
  } cfg_t;

  // one input item
  typedef struct packed {
    logic             action;
    dir_t             ra_direction;
    logic [DUR_W-1:0] ra_duration;
    dir_t             dec_direction;
    logic [DUR_W-1:0] dec_duration;
  } item_t;

  // axis result toward the port builder
  typedef struct packed {
    dir_t dir;
    logic changed;
  } axis_stat_t;

endpackage

// ===== src/guide_port_pulse_timer_unit.sv =====
// top level of the two-axis guide port pulse timer
//
//  channel | direction | ports                          | contents
//  in      | slave     | in_tvalid/tready/tdata/tuser   | tick or pulse request
//  out     | master    | out_tvalid/tready/tdata        | new port byte
//  cfg     | write     | cfg_we/cfg_index/cfg_wdata     | four setup registers
//
// One item per cycle unless a stall on out holds the input stage: an item is
// registered on transfer, then passes through the axis and pin logic into the
// output register.
// Reset is synchronous and active low; it needs no clearing pass.
// A stall on out only holds the input stage when the held item makes a result.
module guide_port_pulse_timer_unit #(
  parameter int PIN_COUNT = gpt_pkg::PIN_COUNT_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // ra_direction[1:0], ra_duration[17:2],
                                  // dec_direction[19:18], dec_duration[35:20], zeros
  input  logic        in_tuser,   // action: 0 tick, 1 pulse request
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // port_byte[7:0]
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [23:0] cfg_wdata
);
  import gpt_pkg::*;

  cfg_t              cfg_r;
  item_t             item_r;
  logic              in_valid_r;
  logic              out_valid_r;
  logic [PORT_W-1:0] out_byte_r;
  axis_stat_t        ra_stat, dec_stat;
  logic              changed, advance, commit, is_tick;
  logic [PORT_W-1:0] port_byte;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pin_action_map  <= '0;
      cfg_r.invert_output   <= 1'b0;
      cfg_r.deadtime_enable <= 1'b0;
      cfg_r.deadtime_ms     <= DEADTIME_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PIN_ACTION_MAP:  cfg_r.pin_action_map  <= cfg_wdata;
        REG_INVERT_OUTPUT:   cfg_r.invert_output   <= cfg_wdata[0];
        REG_DEADTIME_ENABLE: cfg_r.deadtime_enable <= cfg_wdata[0];
        REG_DEADTIME_MS:     cfg_r.deadtime_ms     <= cfg_wdata[DUR_W-1:0];
        default: ;
      endcase
    end
  end

  // flow control between input and output registers
  assign is_tick   = (item_r.action == KIND_TICK);
  assign changed   = ra_stat.changed || dec_stat.changed;
  assign advance   = in_valid_r && (!changed || !out_valid_r || out_tready);
  assign commit    = advance && changed;
  assign in_tready = !in_valid_r || advance;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      item_r.action        <= in_tuser;
      item_r.ra_direction  <= in_tdata[1:0];
      item_r.ra_duration   <= in_tdata[17:2];
      item_r.dec_direction <= in_tdata[19:18];
      item_r.dec_duration  <= in_tdata[35:20];
    end
  end

  // axis state
  gpt_axis u_ra (
    .clk     (clk),
    .rst_n   (rst_n),
    .commit  (advance),
    .is_tick (is_tick),
    .req_dir (item_r.ra_direction),
    .req_dur (item_r.ra_duration),
    .stat    (ra_stat)
  );

  gpt_axis u_dec (
    .clk     (clk),
    .rst_n   (rst_n),
    .commit  (advance),
    .is_tick (is_tick),
    .req_dir (item_r.dec_direction),
    .req_dur (item_r.dec_duration),
    .stat    (dec_stat)
  );

  // pin byte and dead-time
  gpt_port #(
    .PIN_COUNT (PIN_COUNT)
  ) u_port (
    .clk       (clk),
    .rst_n     (rst_n),
    .tick_step (advance && is_tick),
    .commit    (commit),
    .ra_dir    (ra_stat.dir),
    .dec_dir   (dec_stat.dir),
    .cfg       (cfg_r),
    .port_byte (port_byte)
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (commit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      out_byte_r <= port_byte;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_byte_r;

endmodule

// ===== src/gpt_axis.sv =====
// pulse state of one axis: direction, length and elapsed time
module gpt_axis (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     commit,
  input  logic                     is_tick,
  input  gpt_pkg::dir_t            req_dir,
  input  logic [gpt_pkg::DUR_W-1:0] req_dur,
  output gpt_pkg::axis_stat_t      stat
);
  import gpt_pkg::*;

  dir_t             dir_r, dir_nxt;
  logic [DUR_W-1:0] len_r, len_nxt;
  logic [DUR_W-1:0] elapsed_r, elapsed_nxt;
  logic             changed;

  // tick advance or request takeover
  always_comb begin
    logic [DUR_W-1:0] el_inc;
    dir_nxt     = dir_r;
    len_nxt     = len_r;
    elapsed_nxt = elapsed_r;
    changed     = 1'b0;
    el_inc      = (elapsed_r != ELAPSED_MAX) ? elapsed_r + 16'd1 : elapsed_r;
    if (is_tick) begin
      if (dir_r != DIR_NONE) begin
        elapsed_nxt = el_inc;
        if (el_inc >= len_r) begin
          dir_nxt = DIR_NONE;
          changed = 1'b1;
        end
      end
    end else if (req_dir == DIR_PLUS || req_dir == DIR_MINUS) begin
      len_nxt     = req_dur;
      elapsed_nxt = '0;
      changed     = 1'b1;
      // zero length ends the pulse at once
      dir_nxt     = (req_dur == '0) ? DIR_NONE : req_dir;
    end
  end

  assign stat.dir     = dir_nxt;
  assign stat.changed = changed;

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dir_r     <= DIR_NONE;
      len_r     <= '0;
      elapsed_r <= '0;
    end else if (commit) begin
      dir_r     <= dir_nxt;
      len_r     <= len_nxt;
      elapsed_r <= elapsed_nxt;
    end
  end

endmodule

// ===== src/gpt_port.sv =====
// port byte builder with inversion and relay dead-time per pin
module gpt_port #(
  parameter int PIN_COUNT = gpt_pkg::PIN_COUNT_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       tick_step,
  input  logic                       commit,
  input  gpt_pkg::dir_t              ra_dir,
  input  gpt_pkg::dir_t              dec_dir,
  input  gpt_pkg::cfg_t              cfg,
  output logic [gpt_pkg::PORT_W-1:0] port_byte
);
  import gpt_pkg::*;

  logic [PORT_W-1:0] port_level_r;
  logic [DUR_W-1:0]  since_r [PIN_COUNT];
  act_t              ra_code, dec_code;

  // action codes that the active directions drive
  always_comb begin
    case (ra_dir)
      DIR_PLUS:  ra_code = ACT_RA_PLUS;
      DIR_MINUS: ra_code = ACT_RA_MINUS;
      default:   ra_code = ACT_NONE;
    endcase
    case (dec_dir)
      DIR_PLUS:  dec_code = ACT_DEC_PLUS;
      DIR_MINUS: dec_code = ACT_DEC_MINUS;
      default:   dec_code = ACT_NONE;
    endcase
  end

  // one slice per pin
  for (genvar i = 0; i < PORT_W; i++) begin : g_pin
    if (i < PIN_COUNT) begin : g_used
      act_t             code;
      logic             want, built, blocked, rel;
      logic [DUR_W-1:0] since_inc, since_nxt;

      assign code  = cfg.pin_action_map[ACT_W*i +: ACT_W];
      assign want  = (ra_code != ACT_NONE && code == ra_code) ||
                     (dec_code != ACT_NONE && code == dec_code);
      assign built = want ^ cfg.invert_output;

      // saturating ms counter since last release
      assign since_inc = (tick_step && since_r[i] != SINCE_MAX) ?
                         since_r[i] + 16'd1 : since_r[i];

      // hold a pin low that was released too recently
      assign blocked = cfg.deadtime_enable && built && !port_level_r[i] &&
                       (since_inc < cfg.deadtime_ms);
      assign rel     = cfg.deadtime_enable && !built && port_level_r[i];
      assign port_byte[i] = built && !blocked;

      assign since_nxt = (commit && rel) ? '0 : since_inc;

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          since_r[i] <= SINCE_MAX;
        end else begin
          since_r[i] <= since_nxt;
        end
      end
    end else begin : g_unused
      assign port_byte[i] = 1'b0;
    end
  end

  // last level driven on the port
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      port_level_r <= '0;
    end else if (commit) begin
      port_level_r <= port_byte;
    end
  end

endmodule

// ===== verif/tb.sv =====
// self-checking testbench for the two-axis guide port pulse timer
module tb;
  import gpt_pkg::*;

  // pin codes that map to no direction
  localparam act_t ACT_SPARE_5 = 3'd5;
  localparam act_t ACT_SPARE_6 = 3'd6;
  localparam act_t ACT_SPARE_7 = 3'd7;
  // direction code outside the defined set, taken as none
  localparam dir_t DIR_SPARE   = 2'd3;
  localparam int   CYCLE_LIMIT = 300000;
  localparam int   MAX_REPORTS = 10;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [39:0] in_tdata   = '0;
  logic        in_tuser   = KIND_TICK;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;
  logic        cfg_we     = 1'b0;
  logic [1:0]  cfg_index  = REG_PIN_ACTION_MAP;
  logic [23:0] cfg_wdata  = '0;

  // stimulus pacing, receiver hold-off and error bookkeeping
  int send_idle_pct = 34;
  int recv_idle_pct = 45;
  int rx_hold_left  = 0;
  int error_count   = 0;
  int cycle_count   = 0;

  // predicted port state and register shadow
  cfg_t        port_cfg;
  dir_t        axis_dir [2];
  logic [15:0] axis_len [2];
  logic [15:0] axis_el [2];
  logic [15:0] since_rel [8];
  logic [7:0]  port_lvl;
  logic [7:0]  port_expected [$];

  guide_port_pulse_timer_unit u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // run watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: errors");
      $finish;
    end
  end

  // receiver: long hold-off on request, otherwise random stalls
  always @(posedge clk) begin
    if (rx_hold_left > 0) begin
      out_tready <= 1'b0;
      rx_hold_left--;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // result checker, sampled mid-cycle when the transfer is already settled
  always @(negedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (port_expected.size() == 0) begin
        error_count++;
        if (error_count <= MAX_REPORTS)
          $display("port byte %02h arrived with nothing pending", out_tdata);
      end else begin
        if (out_tdata !== port_expected[0]) begin
          error_count++;
          if (error_count <= MAX_REPORTS)
            $display("port byte mismatch: expected %02h, got %02h",
                     port_expected[0], out_tdata);
        end
        void'(port_expected.pop_front());
      end
    end
  end

  // step the port prediction by one accepted item
  task automatic predict_port(input logic kind, input dir_t ra_d, input logic [15:0] ra_t,
                              input dir_t dec_d, input logic [15:0] dec_t);
    logic        changed;
    logic [7:0]  lvl;
    dir_t        req_dir [2];
    logic [15:0] req_dur [2];
    act_t        want [2];
    act_t        code;
    changed    = 1'b0;
    req_dir[0] = ra_d;
    req_dir[1] = dec_d;
    req_dur[0] = ra_t;
    req_dur[1] = dec_t;
    if (kind == KIND_TICK) begin
      // release timers first, then running pulses
      for (int i = 0; i < 8; i++)
        if (since_rel[i] != SINCE_MAX) since_rel[i]++;
      for (int a = 0; a < 2; a++) begin
        if (axis_dir[a] != DIR_NONE) begin
          if (axis_el[a] != ELAPSED_MAX) axis_el[a]++;
          if (axis_el[a] >= axis_len[a]) begin
            axis_dir[a] = DIR_NONE;
            changed     = 1'b1;
          end
        end
      end
    end else begin
      // a given direction restarts that axis
      for (int a = 0; a < 2; a++) begin
        if (req_dir[a] == DIR_PLUS || req_dir[a] == DIR_MINUS) begin
          axis_dir[a] = (req_dur[a] == 0) ? DIR_NONE : req_dir[a];
          axis_len[a] = req_dur[a];
          axis_el[a]  = '0;
          changed     = 1'b1;
        end
      end
    end
    if (!changed) return;

    // build the pin byte
    want[0] = (axis_dir[0] == DIR_PLUS) ? ACT_RA_PLUS :
              (axis_dir[0] == DIR_MINUS) ? ACT_RA_MINUS : ACT_NONE;
    want[1] = (axis_dir[1] == DIR_PLUS) ? ACT_DEC_PLUS :
              (axis_dir[1] == DIR_MINUS) ? ACT_DEC_MINUS : ACT_NONE;
    for (int i = 0; i < 8; i++) begin
      code   = port_cfg.pin_action_map[3*i +: 3];
      lvl[i] = (want[0] != ACT_NONE && code == want[0]) ||
               (want[1] != ACT_NONE && code == want[1]);
    end
    if (port_cfg.invert_output) lvl = ~lvl;

    // relay dead-time against the previous levels
    if (port_cfg.deadtime_enable) begin
      for (int i = 0; i < 8; i++) begin
        if (lvl[i]) begin
          if (!port_lvl[i] && since_rel[i] < port_cfg.deadtime_ms) lvl[i] = 1'b0;
        end else if (port_lvl[i]) begin
          since_rel[i] = '0;
        end
      end
    end
    port_lvl = lvl;
    port_expected.push_back(lvl);
  endtask

  // offer one item until it is taken, with random sender gaps
  task automatic send_item(input logic kind, input dir_t ra_d, input logic [15:0] ra_t,
                           input dir_t dec_d, input logic [15:0] dec_t);
    logic taken;
    taken = 1'b0;
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {4'b0000, dec_t, dec_d, ra_t, ra_d};
    while (!taken) begin
      @(negedge clk);
      taken = in_tready;
      @(posedge clk);
    end
    predict_port(kind, ra_d, ra_t, dec_d, dec_t);
  endtask

  task automatic send_tick();
    send_item(KIND_TICK, dir_t'($urandom), 16'($urandom), dir_t'($urandom), 16'($urandom));
  endtask

  // stop offering and wait for every pending port byte plus pipeline slack
  task automatic drain();
    in_tvalid <= 1'b0;
    while (port_expected.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [23:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_PIN_ACTION_MAP:  port_cfg.pin_action_map  = val;
      REG_INVERT_OUTPUT:   port_cfg.invert_output   = val[0];
      REG_DEADTIME_ENABLE: port_cfg.deadtime_enable = val[0];
      REG_DEADTIME_MS:     port_cfg.deadtime_ms     = val[15:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic configure(input logic [23:0] map, input logic inv, input logic dt_en,
                           input logic [15:0] dt_ms);
    drain();
    write_reg(REG_PIN_ACTION_MAP, map);
    write_reg(REG_INVERT_OUTPUT, {23'd0, inv});
    write_reg(REG_DEADTIME_ENABLE, {23'd0, dt_en});
    write_reg(REG_DEADTIME_MS, {8'd0, dt_ms});
  endtask

  // mostly real directions, now and then the spare code
  function automatic dir_t rand_dir();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return DIR_SPARE;
    if (r < 7) return DIR_NONE;
    if (r < 14) return DIR_PLUS;
    return DIR_MINUS;
  endfunction

  // short pulses dominate so that most of them end within a tick burst
  function automatic logic [15:0] rand_dur();
    int r;
    r = $urandom_range(0, 49);
    if (r == 0) return 16'hFFFF;
    if (r == 1) return 16'($urandom);
    return 16'($urandom_range(0, 12));
  endfunction

  // reset config: no pin is mapped, so every byte is zero
  task automatic test_reset_defaults();
    send_item(KIND_REQUEST, DIR_PLUS, 16'd1, DIR_MINUS, 16'd2);
    send_tick();
    send_tick();
  endtask

  // every action code, zero and full durations, ignored requests and tick fields
  task automatic test_directed_pulses();
    configure({ACT_SPARE_7, ACT_SPARE_6, ACT_SPARE_5, ACT_NONE,
               ACT_DEC_MINUS, ACT_DEC_PLUS, ACT_RA_MINUS, ACT_RA_PLUS},
              1'b0, 1'b0, DEADTIME_RST);
    send_item(KIND_REQUEST, DIR_PLUS, 16'd3, DIR_MINUS, 16'd0);
    send_item(KIND_REQUEST, DIR_NONE, 16'hFFFF, DIR_NONE, 16'hFFFF);
    send_item(KIND_REQUEST, DIR_SPARE, 16'd5, DIR_SPARE, 16'd5);
    send_item(KIND_TICK, DIR_SPARE, 16'hFFFF, DIR_SPARE, 16'hFFFF);
    send_item(KIND_TICK, DIR_NONE, 16'h0000, DIR_NONE, 16'h0000);
    send_tick();
    send_item(KIND_REQUEST, DIR_MINUS, 16'hFFFF, DIR_PLUS, 16'hFFFF);
    send_item(KIND_REQUEST, DIR_PLUS, 16'd2, DIR_NONE, 16'd9);
    send_tick();
    send_tick();
    send_item(KIND_REQUEST, DIR_SPARE, 16'd4, DIR_MINUS, 16'd1);
    send_tick();
    send_item(KIND_REQUEST, DIR_MINUS, 16'd0, DIR_PLUS, 16'd0);
    send_item(KIND_REQUEST, DIR_MINUS, 16'd1, DIR_MINUS, 16'd1);
    send_tick();
  endtask

  // release then re-set inside and after the dead time, plus inversion
  task automatic test_deadtime_invert();
    configure({8{ACT_RA_PLUS}}, 1'b0, 1'b1, 16'd3);
    send_item(KIND_REQUEST, DIR_PLUS, 16'd1, DIR_NONE, 16'd0);
    send_tick();
    send_item(KIND_REQUEST, DIR_PLUS, 16'd6, DIR_NONE, 16'd0);
    send_tick();
    send_tick();
    send_tick();
    send_item(KIND_REQUEST, DIR_PLUS, 16'd2, DIR_PLUS, 16'd1);
    send_tick();
    send_tick();
    configure({4{ACT_DEC_PLUS, ACT_RA_MINUS}}, 1'b1, 1'b1, 16'd2);
    send_item(KIND_REQUEST, DIR_MINUS, 16'd1, DIR_PLUS, 16'd3);
    send_tick();
    send_tick();
    send_tick();
    send_item(KIND_REQUEST, DIR_NONE, 16'd0, DIR_PLUS, 16'd1);
  endtask

  // hold the receiver off long enough to back the block up into its input
  task automatic test_output_backpressure();
    rx_hold_left = 300;
    for (int i = 0; i < 40; i++)
      send_item(KIND_REQUEST, (i % 2) ? DIR_PLUS : DIR_MINUS, rand_dur(),
                rand_dir(), rand_dur());
    drain();
  endtask

  // request followed by a burst of ticks, random content throughout
  task automatic test_random_pulses(input int n);
    int sent;
    int burst;
    sent = 0;
    while (sent < n) begin
      send_item(KIND_REQUEST, rand_dir(), rand_dur(), rand_dir(), rand_dur());
      sent++;
      burst = $urandom_range(0, 14);
      repeat (burst) begin
        send_tick();
        sent++;
      end
    end
  endtask

  initial begin
    port_cfg.pin_action_map  = '0;
    port_cfg.invert_output   = 1'b0;
    port_cfg.deadtime_enable = 1'b0;
    port_cfg.deadtime_ms     = DEADTIME_RST;
    for (int a = 0; a < 2; a++) begin
      axis_dir[a] = DIR_NONE;
      axis_len[a] = '0;
      axis_el[a]  = '0;
    end
    for (int i = 0; i < 8; i++) since_rel[i] = SINCE_MAX;
    port_lvl = '0;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // sender idles less than receiver
    send_idle_pct = 34;
    recv_idle_pct = 45;
    test_reset_defaults();
    test_directed_pulses();
    test_deadtime_invert();
    configure(24'($urandom), 1'b0, 1'b1, 16'($urandom_range(0, 10)));
    test_random_pulses(290);
    configure(24'hFFFFFF, 1'b1, 1'b1, 16'd0);
    test_random_pulses(290);

    // receiver idles less than sender
    send_idle_pct = 45;
    recv_idle_pct = 34;
    configure(24'($urandom), 1'($urandom), 1'b1, 16'hFFFF);
    test_random_pulses(290);
    configure(24'($urandom), 1'b0, 1'b0, DEADTIME_RST);
    test_random_pulses(290);

    // no idling on either side
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_output_backpressure();
    configure(24'($urandom), 1'b1, 1'b1, 16'd2);
    test_random_pulses(290);
    configure(24'($urandom), 1'($urandom), 1'b1, 16'($urandom_range(0, 20)));
    test_random_pulses(290);

    // wind down and look for stragglers
    drain();
    repeat (10) @(posedge clk);
    error_count += port_expected.size();
    if (error_count == 0)
      $display("tb: clean");
    else
      $display("tb: errors");
    $finish;
  end

endmodule
